@@ rtl/core/mpfg_pkg.sv @@
// ----------------------------------------------------------------------------
// mpfg_pkg
// Shared constants, types and byte functions of the magic packet frame
// generator.
// ----------------------------------------------------------------------------
package mpfg_pkg;

  localparam int FRAME_BYTES = 666;
  localparam int MAC_REPEATS = 16;

  localparam int MAC_W      = 48;
  localparam int BEAT_BYTES = 16;
  localparam int NUM_BEATS  = (FRAME_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
  localparam int BEAT_W     = 6;
  localparam int IDX_W      = 11;
  localparam int VB_W       = 5;
  localparam int LAST_BYTES = FRAME_BYTES - BEAT_BYTES * (NUM_BEATS - 1);

  localparam int PAYLOAD_AT = 42;
  localparam int SYNC_END   = PAYLOAD_AT + 6;
  localparam int MAC_END    = SYNC_END + 6 * MAC_REPEATS;

  localparam int IP_LEN  = FRAME_BYTES - 14;
  localparam int UDP_LEN = FRAME_BYTES - 34;

  // Internet checksum of the IPv4 header, fixed once the frame length is.
  localparam logic [31:0] CSUM_RAW = 32'h0000_4500 + 32'(IP_LEN) + 32'h0000_0111
                                   + 32'h0003_FFFC;
  localparam logic [31:0] CSUM_F1  = (CSUM_RAW >> 16) + (CSUM_RAW & 32'h0000_FFFF);
  localparam logic [31:0] CSUM_F2  = CSUM_F1 + (CSUM_F1 >> 16);
  localparam logic [15:0] IP_CSUM  = ~CSUM_F2[15:0];

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [0:0] REG_SOURCE_MAC = 1'b0;

  typedef struct packed {
    logic             valid;
    logic [MAC_W-1:0] mac;
  } mac_req_t;

  function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac,
                                          input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0:    r = mac[47:40];
      3'd1:    r = mac[39:32];
      3'd2:    r = mac[31:24];
      3'd3:    r = mac[23:16];
      3'd4:    r = mac[15:8];
      3'd5:    r = mac[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Reduces a value below 24 modulo six.
  function automatic logic [2:0] mod6(input logic [4:0] v);
    logic [4:0] r;
    if (v >= 5'd18)      r = v - 5'd18;
    else if (v >= 5'd12) r = v - 5'd12;
    else if (v >= 5'd6)  r = v - 5'd6;
    else                 r = v;
    return r[2:0];
  endfunction

  // Fixed header bytes from the EtherType up to the end of the UDP header.
  function automatic logic [7:0] header_byte(input logic [5:0] pos);
    logic [7:0] r;
    case (pos) inside
      6'd12:           r = 8'h08;
      6'd14:           r = 8'h45;
      6'd16:           r = 8'(IP_LEN >> 8);
      6'd17:           r = 8'(IP_LEN);
      6'd22:           r = 8'h01;
      6'd23:           r = 8'd17;
      6'd24:           r = IP_CSUM[15:8];
      6'd25:           r = IP_CSUM[7:0];
      [6'd26:6'd33]:   r = 8'hFF;
      6'd38:           r = 8'(UDP_LEN >> 8);
      6'd39:           r = 8'(UDP_LEN);
      default:         r = 8'h00;
    endcase
    return r;
  endfunction

  // One frame byte; k is the position within the repeated MAC for payload bytes.
  function automatic logic [7:0] frame_byte(input logic [IDX_W-1:0] idx,
                                            input logic [2:0]       k,
                                            input logic [MAC_W-1:0] tgt,
                                            input logic [MAC_W-1:0] src);
    logic [7:0] r;
    if (idx >= IDX_W'(FRAME_BYTES))     r = 8'h00;
    else if (idx < IDX_W'(6))           r = mac_byte(tgt, idx[2:0]);
    else if (idx < IDX_W'(12))          r = mac_byte(src, 3'(idx[3:0] - 4'd6));
    else if (idx < IDX_W'(PAYLOAD_AT))  r = header_byte(idx[5:0]);
    else if (idx < IDX_W'(SYNC_END))    r = 8'hFF;
    else if (idx < IDX_W'(MAC_END))     r = mac_byte(tgt, k);
    else                                r = 8'h00;
    return r;
  endfunction

endpackage

@@ rtl/core/mpfg_if.sv @@
// ----------------------------------------------------------------------------
// mpfg_if
// Request and beat channel interfaces of the magic packet frame generator.
// ----------------------------------------------------------------------------
interface mpfg_req_if;
  logic                     valid;
  logic                     ready;
  logic [mpfg_pkg::MAC_W-1:0] target_mac;

  modport source (output valid, output target_mac, input ready);
  modport sink   (input valid, input target_mac, output ready);
endinterface

interface mpfg_beat_if;
  logic                        valid;
  logic                        ready;
  logic [63:0]                 beat_front;
  logic [63:0]                 beat_back;
  logic [mpfg_pkg::VB_W-1:0]   valid_bytes;
  logic                        last_beat;

  modport source (output valid, output beat_front, output beat_back,
                  output valid_bytes, output last_beat, input ready);
  modport sink   (input valid, input beat_front, input beat_back,
                  input valid_bytes, input last_beat, output ready);
endinterface

@@ rtl/core/magic_packet_frame_generator_top.sv @@
// ----------------------------------------------------------------------------
// magic_packet_frame_generator_top
// Builds a wake-on-LAN UDP broadcast frame for each requested target MAC.
//
//   Channel  Dir  Handshake      Carries
//   req      in   valid/ready    target_mac (48 bits)
//   beat     out  valid/ready    beat_front, beat_back, valid_bytes, last_beat
//   apb      in   psel/penable   source_mac at byte address 0 (64-bit data)
//
// Each request yields 42 beats, one per cycle while the sink is ready; the
// beat generator writing one beat a cycle into the output register sets that.
// Frames run back to back: the first beat of the next frame follows the last
// beat of the current one. Up to two requests wait in the queue, plus one in
// the intake register. Synchronous reset clears all control state and the
// source MAC register; a stalled sink holds the beat and, once the queue
// fills, the request channel.
// ----------------------------------------------------------------------------
module magic_packet_frame_generator_top (
  input  logic        clk,
  input  logic        rst,
  mpfg_req_if.sink    req,
  mpfg_beat_if.source beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import mpfg_pkg::*;

  logic [MAC_W-1:0] source_mac;
  mac_req_t         push;
  mac_req_t         head;
  logic             queue_full;
  logic             pop;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_SOURCE_MAC) ? {16'h0000, source_mac} : 64'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_mac <= '0;
    end else if (psel && penable && pwrite && pready && paddr[3] == REG_SOURCE_MAC) begin
      source_mac <= pwdata[MAC_W-1:0];
    end
  end

  mpfg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push       (push),
    .queue_full (queue_full)
  );

  mpfg_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .head (head),
    .pop  (pop)
  );

  mpfg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .source_mac (source_mac),
    .beat       (beat)
  );

endmodule

@@ rtl/core/mpfg_front.sv @@
// ----------------------------------------------------------------------------
// mpfg_front
// Request intake: registers each incoming target MAC and pushes it into the
// frame queue as soon as there is room.
// ----------------------------------------------------------------------------
module mpfg_front (
  input  logic               clk,
  input  logic               rst,
  mpfg_req_if.sink           req,
  output mpfg_pkg::mac_req_t push,
  input  logic               queue_full
);
  import mpfg_pkg::*;

  logic             hold_valid;
  logic [MAC_W-1:0] hold_mac;
  logic             push_ok;

  assign push_ok   = hold_valid && !queue_full;
  assign req.ready = !hold_valid || push_ok;

  assign push.valid = push_ok;
  assign push.mac   = hold_mac;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req.ready) begin
      hold_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      hold_mac <= req.target_mac;
    end
  end

endmodule

@@ rtl/core/mpfg_queue.sv @@
// ----------------------------------------------------------------------------
// mpfg_queue
// Short queue of pending target MACs between intake and frame builder.
// ----------------------------------------------------------------------------
module mpfg_queue (
  input  logic               clk,
  input  logic               rst,
  input  mpfg_pkg::mac_req_t push,
  output logic               full,
  output mpfg_pkg::mac_req_t head,
  input  logic               pop
);
  import mpfg_pkg::*;

  logic [MAC_W-1:0]  slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.mac   = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.mac;
    end
  end

endmodule

@@ rtl/core/mpfg_back.sv @@
// ----------------------------------------------------------------------------
// mpfg_back
// Frame builder: takes one target MAC from the queue and produces the frame
// as a run of sixteen-byte beats into an output register.
// ----------------------------------------------------------------------------
module mpfg_back (
  input  logic                       clk,
  input  logic                       rst,
  input  mpfg_pkg::mac_req_t         head,
  output logic                       pop,
  input  logic [mpfg_pkg::MAC_W-1:0] source_mac,
  mpfg_beat_if.source                beat
);
  import mpfg_pkg::*;

  logic              busy;
  logic [BEAT_W-1:0] beat_cnt;
  logic [2:0]        phase;
  logic [MAC_W-1:0]  held_target;
  logic              out_valid;
  logic              advance;
  logic              gen;
  logic              last;
  logic              load;
  logic [7:0]        bytes [BEAT_BYTES];
  logic [63:0]       front_next;
  logic [63:0]       back_next;

  assign advance = !out_valid || beat.ready;
  assign gen     = busy && advance;
  assign last    = (beat_cnt == BEAT_W'(NUM_BEATS - 1));
  // The next frame is taken while the last beat of this one is written, so
  // frames follow one another without a gap.
  assign load    = head.valid && (!busy || (gen && last));
  assign pop     = load;

  assign beat.valid = out_valid;

  // The phase is the position within the repeated MAC of the beat's first
  // byte, counted from the start of the MAC copies.
  always_comb begin
    for (int b = 0; b < BEAT_BYTES; b++) begin
      bytes[b] = frame_byte({1'b0, beat_cnt, 4'(b)},
                            mod6(5'(phase) + 5'(b)), held_target, source_mac);
    end
    for (int b = 0; b < 8; b++) begin
      front_next[63 - 8*b -: 8] = bytes[b];
      back_next[63 - 8*b -: 8]  = bytes[b + 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      beat_cnt  <= '0;
      phase     <= '0;
    end else begin
      if (advance) begin
        out_valid <= gen;
      end
      if (load) begin
        busy     <= 1'b1;
        beat_cnt <= '0;
        phase    <= '0;
      end else if (gen) begin
        if (last) begin
          busy <= 1'b0;
        end
        beat_cnt <= beat_cnt + 1'b1;
        phase    <= (phase >= 3'd2) ? phase - 3'd2 : phase + 3'd4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_target <= head.mac;
    end
    if (gen) begin
      beat.beat_front  <= front_next;
      beat.beat_back   <= back_next;
      beat.valid_bytes <= last ? VB_W'(LAST_BYTES) : VB_W'(BEAT_BYTES);
      beat.last_beat   <= last;
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the magic packet frame generator. A driver
// offers target MAC requests from a pending queue and a monitor checks every
// beat against frames predicted in the testbench, under several source MAC
// settings and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

  import mpfg_pkg::*;

  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          LONG_HOLD      = 400;
  localparam int          END_SETTLE     = 60;
  localparam logic [3:0]  SRC_MAC_ADDR   = {REG_SOURCE_MAC, 3'b000};
  localparam logic [3:0]  UNMAPPED_ADDR  = 4'd8;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] IPV4_TOTAL_LEN = 16'(FRAME_BYTES - 14);
  localparam logic [15:0] UDP_TOTAL_LEN  = 16'(FRAME_BYTES - 34);
  localparam int          SYNC_START     = 42;
  localparam int          REPEAT_START   = SYNC_START + 6;
  localparam int          REPEAT_STOP    = REPEAT_START + 6 * MAC_REPEATS;

  typedef struct {
    logic [63:0]     front;
    logic [63:0]     back;
    logic [VB_W-1:0] nbytes;
    logic            last;
  } wol_beat_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  mpfg_req_if  req_ch ();
  mpfg_beat_if beat_ch ();

  magic_packet_frame_generator_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .beat    (beat_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [MAC_W-1:0] pending_macs[$];
  wol_beat_t        beats_due[$];
  logic [MAC_W-1:0] src_mac_shadow;
  int               err_count;
  int               send_idle_pct;
  int               stall_pct;
  int               hold_req;
  int               hold_seen;
  int               hold_left;
  int               quiet_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    err_count++;
  endtask

  function automatic logic [15:0] ipv4_header_csum();
    logic [15:0] words [10];
    logic [31:0] acc;
    words = '{16'h4500, IPV4_TOTAL_LEN, 16'h0000, 16'h0000, 16'h0111, 16'h0000,
              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    acc = 32'd0;
    foreach (words[w]) acc += {16'd0, words[w]};
    while (acc[31:16] != 16'd0) acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  function automatic logic [7:0] wol_frame_octet(input int idx,
                                                 input logic [MAC_W-1:0] tgt,
                                                 input logic [MAC_W-1:0] src,
                                                 input logic [15:0] csum);
    logic [7:0] r;
    r = 8'h00;
    if (idx >= FRAME_BYTES)      r = 8'h00;
    else if (idx < 6)            r = tgt[47 - 8 * idx -: 8];
    else if (idx < 12)           r = src[47 - 8 * (idx - 6) -: 8];
    else if (idx == 12)          r = 8'h08;
    else if (idx == 14)          r = 8'h45;
    else if (idx == 16)          r = IPV4_TOTAL_LEN[15:8];
    else if (idx == 17)          r = IPV4_TOTAL_LEN[7:0];
    else if (idx == 22)          r = 8'h01;
    else if (idx == 23)          r = PROTO_UDP;
    else if (idx == 24)          r = csum[15:8];
    else if (idx == 25)          r = csum[7:0];
    else if (idx >= 26 && idx < 34) r = 8'hFF;
    else if (idx == 38)          r = UDP_TOTAL_LEN[15:8];
    else if (idx == 39)          r = UDP_TOTAL_LEN[7:0];
    else if (idx < SYNC_START)   r = 8'h00;
    else if (idx < REPEAT_START) r = 8'hFF;
    else if (idx < REPEAT_STOP)  r = tgt[47 - 8 * ((idx - REPEAT_START) % 6) -: 8];
    return r;
  endfunction

  // Queues every beat of the frame that one accepted request should produce.
  task automatic predict_frame(input logic [MAC_W-1:0] tgt);
    wol_beat_t   bt;
    int          base;
    logic [15:0] csum;
    csum = ipv4_header_csum();
    for (int b = 0; b < NUM_BEATS; b++) begin
      base = b * BEAT_BYTES;
      bt.front = '0;
      bt.back  = '0;
      for (int k = 0; k < 8; k++) begin
        bt.front = {bt.front[55:0], wol_frame_octet(base + k, tgt, src_mac_shadow, csum)};
        bt.back  = {bt.back[55:0], wol_frame_octet(base + 8 + k, tgt, src_mac_shadow, csum)};
      end
      bt.nbytes = VB_W'((FRAME_BYTES - base > BEAT_BYTES) ? BEAT_BYTES : FRAME_BYTES - base);
      bt.last   = (b == NUM_BEATS - 1);
      beats_due.push_back(bt);
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_macs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid      <= 1'b1;
        req_ch.target_mac <= pending_macs.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Beat receiver; a long hold keeps ready low while requests keep coming.
  always @(posedge clk) begin
    if (rst) begin
      beat_ch.ready <= 1'b0;
      hold_left     <= 0;
      hold_seen     <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= LONG_HOLD;
      beat_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      beat_ch.ready <= 1'b0;
    end else begin
      beat_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted beat.
  always @(posedge clk) begin
    wol_beat_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) predict_frame(req_ch.target_mac);
      if (beat_ch.valid && beat_ch.ready) begin
        if (beats_due.size() == 0) begin
          report_mismatch("unexpected beat", beat_ch.beat_front, 64'd0);
        end else begin
          want = beats_due.pop_front();
          if (beat_ch.beat_front !== want.front)
            report_mismatch("beat_front", beat_ch.beat_front, want.front);
          if (beat_ch.beat_back !== want.back)
            report_mismatch("beat_back", beat_ch.beat_back, want.back);
          if (beat_ch.valid_bytes !== want.nbytes)
            report_mismatch("valid_bytes", 64'(beat_ch.valid_bytes), 64'(want.nbytes));
          if (beat_ch.last_beat !== want.last)
            report_mismatch("last_beat", 64'(beat_ch.last_beat), 64'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (beat_ch.valid && beat_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == SRC_MAC_ADDR) src_mac_shadow = data[MAC_W-1:0];
  endtask

  task automatic apb_read_check(input logic [3:0] addr, input logic [MAC_W-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[MAC_W-1:0] !== want)
      report_mismatch("source_mac readback", 64'(prdata[MAC_W-1:0]), 64'(want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_frames_done();
    @(negedge clk);
    while (pending_macs.size() != 0 || req_ch.valid || beats_due.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [MAC_W-1:0] m;
    case ($urandom_range(7))
      0:       m = '1;
      1:       m = '0;
      2:       m = {8'($urandom_range(255)), 40'h0};
      default: m = MAC_W'({$urandom, $urandom});
    endcase
    return m;
  endfunction

  task automatic run_phase(input int n, input int idle, input int stall,
                           input bit long_hold);
    @(negedge clk);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < n; i++) pending_macs.push_back(rand_mac());
    if (long_hold) hold_req++;
    wait_frames_done();
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_ch.valid   = 1'b0;
    req_ch.target_mac = '0;
    beat_ch.ready  = 1'b0;
    err_count      = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_req       = 0;
    hold_seen      = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    src_mac_shadow = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed frames with the source MAC still at its reset value.
    @(negedge clk);
    pending_macs = '{48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000,
                     48'h0000_0000_0001, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                     48'h0123_4567_89AB, 48'hFEDC_BA98_7654, 48'hFF00_FF00_FF00,
                     48'h00FF_00FF_00FF};
    wait_frames_done();

    // A write to an unmapped register must leave the source MAC alone.
    apb_write(UNMAPPED_ADDR, {$urandom, $urandom});
    apb_read_check(SRC_MAC_ADDR, src_mac_shadow);
    apb_write(SRC_MAC_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_read_check(SRC_MAC_ADDR, src_mac_shadow);
    @(negedge clk);
    pending_macs = '{48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, rand_mac(), rand_mac()};
    wait_frames_done();

    apb_write(SRC_MAC_ADDR, 64'h5555_AAAA_AAAA_AAAA);
    run_phase(35, 0, 0, 1'b0);

    apb_write(SRC_MAC_ADDR, {$urandom, $urandom});
    apb_write(UNMAPPED_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
    run_phase(35, 66, 0, 1'b0);

    apb_write(SRC_MAC_ADDR, 64'h0000_5555_5555_5555);
    apb_read_check(SRC_MAC_ADDR, src_mac_shadow);
    run_phase(35, 0, 66, 1'b1);

    // The sender waits for the last frame before the source MAC returns to zero.
    apb_write(SRC_MAC_ADDR, 64'h0);
    run_phase(15, 6, 6, 1'b0);
    apb_write(SRC_MAC_ADDR, {$urandom, $urandom});
    run_phase(15, 6, 6, 1'b0);

    repeat (END_SETTLE) @(posedge clk);
    if (err_count == 0 && beats_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (beats_due.size() != 0) report_mismatch("beats never sent", 64'(beats_due.size()), 64'd0);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
